@@ sv/rbch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rbch_pkg;

  localparam int RECIP_WIDTH = 48;
  localparam int HALF_WIDTH  = RECIP_WIDTH / 2;
  localparam logic [RECIP_WIDTH-1:0] RECIP_SAT = {1'b0, {(RECIP_WIDTH-1){1'b1}}};
  localparam int ID_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_DIR_X    = 3'd2,
    REG_DIR_Y    = 3'd3,
    REG_MAX_DIST = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    SU_IDLE,
    SU_SQR,
    SU_SUM,
    SU_ROOT,
    SU_LOAD,
    SU_DIV,
    SU_STORE
  } su_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_CMP,
    BK_PMUL,
    BK_PT
  } bk_state_e;

  typedef struct packed {
    logic busy;
    logic ray_ready;
  } su_status_t;

endpackage
`default_nettype wire

@@ sv/rbch_setup.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rbch_setup #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       start_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       dir_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       dir_y_i,
  output rbch_pkg::su_status_t                      status_o,
  output logic signed [COORD_WIDTH-1:0]             unit_x_o,
  output logic signed [COORD_WIDTH-1:0]             unit_y_o,
  output logic signed [rbch_pkg::RECIP_WIDTH-1:0]   recip_x_o,
  output logic signed [rbch_pkg::RECIP_WIDTH-1:0]   recip_y_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int RW   = rbch_pkg::RECIP_WIDTH;
  localparam int SQW  = 2 * CW + 2;
  localparam int NR   = CW + 1;
  localparam int DSW  = CW + 1;
  localparam int DVW  = (CW + FB > 2 * FB + 1) ? CW + FB : 2 * FB + 1;
  localparam int CNTW = $clog2(DVW + 1);

  rbch_pkg::su_state_e state_q, state_d;

  logic [CW-1:0]         ax, ay, umag;
  logic [2*CW-1:0]       sqx_q, sqy_q;
  logic [SQW-1:0]        rad_q;
  logic [CW+2:0]         rem_q, rem_sh, trial;
  logic                  root_ge;
  logic [CW:0]           root_q;
  logic [DVW-1:0]        num_q, qclamp;
  logic [DSW-1:0]        rdv_q, den_q;
  logic [DSW:0]          r_sh, r_sub;
  logic                  div_ge;
  logic [CNTW-1:0]       cnt_q;
  logic [1:0]            ph_q;
  logic                  ready_q;
  logic signed [CW-1:0]  ux_q, uy_q, unit_val;
  logic signed [RW-1:0]  rx_q, ry_q, recip_val;
  logic [CW-1:0]         uq;
  logic [RW-1:0]         rq;
  logic                  usign, rsign, rzero;

  assign ax = dir_x_i[CW-1] ? -$unsigned(dir_x_i) : $unsigned(dir_x_i);
  assign ay = dir_y_i[CW-1] ? -$unsigned(dir_y_i) : $unsigned(dir_y_i);
  assign umag = ph_q[0] ? (uy_q[CW-1] ? -$unsigned(uy_q) : $unsigned(uy_q))
                        : (ux_q[CW-1] ? -$unsigned(ux_q) : $unsigned(ux_q));

  // one result bit per cycle of the integer square root
  assign rem_sh  = {rem_q[CW:0], rad_q[SQW-1:SQW-2]};
  assign trial   = {root_q, 2'b01};
  assign root_ge = rem_sh >= trial;

  // restoring divider, one quotient bit per cycle
  assign r_sh   = {rdv_q, num_q[DVW-1]};
  assign r_sub  = r_sh - {1'b0, den_q};
  assign div_ge = r_sh >= {1'b0, den_q};

  assign qclamp    = (num_q > (DVW'(1) << FB)) ? (DVW'(1) << FB) : num_q;
  assign uq        = CW'(qclamp);
  assign usign     = ph_q[0] ? dir_y_i[CW-1] : dir_x_i[CW-1];
  assign unit_val  = usign ? -$signed(uq) : $signed(uq);
  assign rq        = RW'(num_q);
  assign rsign     = ph_q[0] ? uy_q[CW-1] : ux_q[CW-1];
  assign rzero     = ph_q[0] ? (uy_q == '0) : (ux_q == '0);
  assign recip_val = rzero ? $signed(rbch_pkg::RECIP_SAT) : (rsign ? -$signed(rq) : $signed(rq));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbch_pkg::SU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbch_pkg::SU_IDLE:  state_d = rbch_pkg::SU_IDLE;
      rbch_pkg::SU_SQR:   state_d = rbch_pkg::SU_SUM;
      rbch_pkg::SU_SUM:   state_d = rbch_pkg::SU_ROOT;
      rbch_pkg::SU_ROOT: begin
        if (cnt_q == CNTW'(1)) state_d = rbch_pkg::SU_LOAD;
      end
      rbch_pkg::SU_LOAD: begin
        if (ph_q == 2'd0 && root_q == '0) state_d = rbch_pkg::SU_IDLE;
        else state_d = rbch_pkg::SU_DIV;
      end
      rbch_pkg::SU_DIV: begin
        if (cnt_q == CNTW'(1)) state_d = rbch_pkg::SU_STORE;
      end
      rbch_pkg::SU_STORE: begin
        if (ph_q == 2'd3) state_d = rbch_pkg::SU_IDLE;
        else state_d = rbch_pkg::SU_LOAD;
      end
      default: state_d = rbch_pkg::SU_IDLE;
    endcase
    // a new direction restarts the sequence
    if (start_i) state_d = rbch_pkg::SU_SQR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= 2'd0;
      ready_q <= 1'b0;
      ux_q    <= '0;
      uy_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
    end else begin
      case (state_q)
        rbch_pkg::SU_SUM: ph_q <= 2'd0;
        rbch_pkg::SU_LOAD: begin
          if (ph_q == 2'd0 && root_q == '0) begin
            ready_q <= 1'b0;
            ux_q    <= '0;
            uy_q    <= '0;
            rx_q    <= '0;
            ry_q    <= '0;
          end
        end
        rbch_pkg::SU_STORE: begin
          case (ph_q)
            2'd0: ux_q <= unit_val;
            2'd1: uy_q <= unit_val;
            2'd2: rx_q <= recip_val;
            2'd3: begin
              ry_q    <= recip_val;
              ready_q <= 1'b1;
            end
            default: ;
          endcase
          ph_q <= ph_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rbch_pkg::SU_SQR: begin
        sqx_q <= (2*CW)'(ax) * (2*CW)'(ax);
        sqy_q <= (2*CW)'(ay) * (2*CW)'(ay);
      end
      rbch_pkg::SU_SUM: begin
        rad_q  <= SQW'(sqx_q) + SQW'(sqy_q);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CNTW'(NR);
      end
      rbch_pkg::SU_ROOT: begin
        rad_q  <= rad_q << 2;
        rem_q  <= root_ge ? rem_sh - trial : rem_sh;
        root_q <= {root_q[CW-1:0], root_ge};
        cnt_q  <= cnt_q - CNTW'(1);
      end
      rbch_pkg::SU_LOAD: begin
        case (ph_q)
          2'd0: begin
            num_q <= DVW'(ax) << FB;
            den_q <= root_q;
          end
          2'd1: begin
            num_q <= DVW'(ay) << FB;
            den_q <= root_q;
          end
          default: begin
            num_q <= DVW'(1) << (2 * FB);
            den_q <= DSW'(umag);
          end
        endcase
        rdv_q <= '0;
        cnt_q <= CNTW'(DVW);
      end
      rbch_pkg::SU_DIV: begin
        rdv_q <= div_ge ? r_sub[DSW-1:0] : r_sh[DSW-1:0];
        num_q <= {num_q[DVW-2:0], div_ge};
        cnt_q <= cnt_q - CNTW'(1);
      end
      default: ;
    endcase
  end

  assign status_o.busy      = (state_q != rbch_pkg::SU_IDLE);
  assign status_o.ray_ready = ready_q;
  assign unit_x_o  = ux_q;
  assign unit_y_o  = uy_q;
  assign recip_x_o = rx_q;
  assign recip_y_o = ry_q;

endmodule
`default_nettype wire

@@ sv/rbch_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rbch_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire  logic signed [COORD_WIDTH-1:0]  box_center_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  box_center_y_i,
  input  wire  logic [COORD_WIDTH-2:0]         box_half_width_i,
  input  wire  logic [COORD_WIDTH-2:0]         box_half_height_i,
  input  wire  logic [rbch_pkg::ID_WIDTH-1:0]  box_id_i,
  input  wire                                  box_active_i,
  input  wire                                  last_box_i,
  input  rbch_pkg::su_status_t                 status_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  origin_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]  origin_y_i,
  output logic                                 push_valid_o,
  input  wire                                  push_ready_i,
  output logic                                 take_o,
  output logic                                 last_o,
  output logic [rbch_pkg::ID_WIDTH-1:0]        id_o,
  output logic signed [COORD_WIDTH+1:0]        dx_lo_o,
  output logic signed [COORD_WIDTH+1:0]        dx_hi_o,
  output logic signed [COORD_WIDTH+1:0]        dy_lo_o,
  output logic signed [COORD_WIDTH+1:0]        dy_hi_o
);

  localparam int DFW = COORD_WIDTH + 2;

  logic stage_q, accept, take, keep;

  assign in_ready_o = !status_i.busy && (!stage_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign take       = box_active_i && status_i.ray_ready;
  // drop skipped boxes that do not close a set
  assign keep       = take || last_box_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
    end else if (accept) begin
      stage_q <= keep;
    end else if (push_ready_i) begin
      stage_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      take_o  <= take;
      last_o  <= last_box_i;
      id_o    <= box_id_i;
      dx_lo_o <= DFW'(box_center_x_i) - DFW'(box_half_width_i) - DFW'(origin_x_i);
      dx_hi_o <= DFW'(box_center_x_i) + DFW'(box_half_width_i) - DFW'(origin_x_i);
      dy_lo_o <= DFW'(box_center_y_i) - DFW'(box_half_height_i) - DFW'(origin_y_i);
      dy_hi_o <= DFW'(box_center_y_i) + DFW'(box_half_height_i) - DFW'(origin_y_i);
    end
  end

  assign push_valid_o = stage_q;

endmodule
`default_nettype wire

@@ sv/rbch_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rbch_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  wire  [WIDTH-1:0]  push_data_i,
  output logic              pop_valid_o,
  input  wire               pop_ready_i,
  output logic [WIDTH-1:0]  pop_data_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + AW'(1);
      if (pop) rd_q <= rd_q + AW'(1);
      if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(DEPTH))
    else $error("fifo count beyond depth");

endmodule
`default_nettype wire

@@ sv/rbch_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rbch_back #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  wire                                       q_valid_i,
  output logic                                      q_ready_o,
  input  wire                                       take_i,
  input  wire                                       last_i,
  input  wire  logic [rbch_pkg::ID_WIDTH-1:0]       id_i,
  input  wire  logic signed [COORD_WIDTH+1:0]       dx_lo_i,
  input  wire  logic signed [COORD_WIDTH+1:0]       dx_hi_i,
  input  wire  logic signed [COORD_WIDTH+1:0]       dy_lo_i,
  input  wire  logic signed [COORD_WIDTH+1:0]       dy_hi_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       origin_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       origin_y_i,
  input  wire  logic [COORD_WIDTH-2:0]              max_distance_i,
  input  wire                                       ray_ready_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       unit_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]       unit_y_i,
  input  wire  logic signed [rbch_pkg::RECIP_WIDTH-1:0] recip_x_i,
  input  wire  logic signed [rbch_pkg::RECIP_WIDTH-1:0] recip_y_i,
  output logic                                      out_valid_o,
  input  wire                                       out_ready_i,
  output logic                                      hit_o,
  output logic [rbch_pkg::ID_WIDTH-1:0]             hit_body_id_o,
  output logic [COORD_WIDTH-2:0]                    hit_distance_o,
  output logic signed [COORD_WIDTH-1:0]             hit_point_x_o,
  output logic signed [COORD_WIDTH-1:0]             hit_point_y_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int RW  = rbch_pkg::RECIP_WIDTH;
  localparam int HW  = rbch_pkg::HALF_WIDTH;
  localparam int DFW = CW + 2;
  localparam int AMW = CW + 1;
  localparam int PPW = AMW + HW;
  localparam int PW  = AMW + RW;
  localparam int TW  = RW + 1;
  localparam int MW  = 2 * CW - 1;
  localparam int VW  = 2 * CW + 1;

  function automatic logic [CW-1:0] hit_coord(input logic signed [CW-1:0] org,
                                                input logic sgn,
                                                input logic [MW-1:0] pm);
    logic [MW-1:0]        p;
    logic signed [VW-1:0] sp;
    logic signed [VW-1:0] v;
    p  = pm >> FB;
    sp = $signed(VW'(p));
    v  = VW'(org) + (sgn ? -sp : sp);
    if ((&v[VW-1:CW-1]) || !(|v[VW-1:CW-1])) hit_coord = v[CW-1:0];
    else if (v[VW-1]) hit_coord = {1'b1, {(CW-1){1'b0}}};
    else hit_coord = {1'b0, {(CW-1){1'b1}}};
  endfunction

  rbch_pkg::bk_state_e state_q, state_d;

  logic [3:0]                    cnt_q;
  logic [AMW-1:0]                amag_q [4];
  logic [3:0]                    neg_q;
  logic [RW-1:0]                 rmx_q, rmy_q, rm_sel;
  logic [HW-1:0]                 b_half;
  logic [PPW-1:0]                pp_q;
  logic [2:0]                    pk_q;
  logic [PW-1:0]                 prod_q [4];
  logic signed [TW-1:0]          t_q [4];
  logic [rbch_pkg::ID_WIDTH-1:0] id_q, best_id_q;
  logic                          last_q, any_q;
  logic [CW-2:0]                 best_q, limit;
  logic [MW-1:0]                 pmx_q, pmy_q;
  logic [CW-1:0]                 umx, umy;
  logic signed [TW-1:0]          lo_x, hi_x, lo_y, hi_y, tmin, tmax, t_sel;
  logic                          slab_hit, better, hit_now, out_load;
  logic signed [DFW-1:0]         diff [4];
  logic signed [TW-1:0]          t_val [4];

  assign diff[0] = dx_lo_i;
  assign diff[1] = dx_hi_i;
  assign diff[2] = dy_lo_i;
  assign diff[3] = dy_hi_i;

  assign q_ready_o = (state_q == rbch_pkg::BK_IDLE);
  assign rm_sel    = cnt_q[2] ? rmy_q : rmx_q;
  assign b_half    = cnt_q[0] ? rm_sel[RW-1:HW] : rm_sel[HW-1:0];
  assign umx = unit_x_i[CW-1] ? -$unsigned(unit_x_i) : $unsigned(unit_x_i);
  assign umy = unit_y_i[CW-1] ? -$unsigned(unit_y_i) : $unsigned(unit_y_i);

  always_comb begin
    logic [PW-1:0] m;
    logic [RW-1:0] ms;
    for (int j = 0; j < 4; j++) begin
      m  = prod_q[j] >> FB;
      ms = (m > PW'(rbch_pkg::RECIP_SAT)) ? rbch_pkg::RECIP_SAT : RW'(m);
      t_val[j] = neg_q[j] ? -$signed(TW'(ms)) : $signed(TW'(ms));
    end
  end

  assign lo_x  = (t_q[0] > t_q[1]) ? t_q[1] : t_q[0];
  assign hi_x  = (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
  assign lo_y  = (t_q[2] > t_q[3]) ? t_q[3] : t_q[2];
  assign hi_y  = (t_q[2] > t_q[3]) ? t_q[2] : t_q[3];
  assign tmin  = (lo_y > lo_x) ? lo_y : lo_x;
  assign tmax  = (hi_y < hi_x) ? hi_y : hi_x;
  assign slab_hit = !(tmin > tmax || tmax < 0);
  assign t_sel = (tmin >= 0) ? tmin : tmax;
  assign limit = any_q ? best_q : max_distance_i;
  assign better = slab_hit && (t_sel >= 0)
                  && (t_sel < $signed({{(TW-CW+1){1'b0}}, limit}));
  assign hit_now  = any_q && ray_ready_i;
  assign out_load = (state_q == rbch_pkg::BK_PT) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbch_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rbch_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          if (take_i) state_d = rbch_pkg::BK_MUL;
          else if (last_i) state_d = rbch_pkg::BK_PMUL;
        end
      end
      rbch_pkg::BK_MUL: begin
        if (cnt_q == 4'd8) state_d = rbch_pkg::BK_SCALE;
      end
      rbch_pkg::BK_SCALE: state_d = rbch_pkg::BK_CMP;
      rbch_pkg::BK_CMP: state_d = last_q ? rbch_pkg::BK_PMUL : rbch_pkg::BK_IDLE;
      rbch_pkg::BK_PMUL: state_d = rbch_pkg::BK_PT;
      rbch_pkg::BK_PT: begin
        if (out_load) state_d = rbch_pkg::BK_IDLE;
      end
      default: state_d = rbch_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 4'd0;
      any_q       <= 1'b0;
      best_q      <= '0;
      best_id_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      case (state_q)
        rbch_pkg::BK_IDLE: cnt_q <= 4'd0;
        rbch_pkg::BK_MUL: cnt_q <= cnt_q + 4'd1;
        rbch_pkg::BK_CMP: begin
          if (better) begin
            best_q    <= (CW-1)'(t_sel);
            best_id_q <= id_q;
            any_q     <= 1'b1;
          end
        end
        rbch_pkg::BK_PT: begin
          // close the set once the result is in the output register
          if (out_load) begin
            any_q     <= 1'b0;
            best_q    <= '0;
            best_id_q <= '0;
          end
        end
        default: ;
      endcase
      if (out_load) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rbch_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          id_q   <= id_i;
          last_q <= last_i;
          for (int j = 0; j < 4; j++) begin
            amag_q[j] <= diff[j][DFW-1] ? AMW'(-diff[j]) : AMW'(diff[j]);
            neg_q[j]  <= diff[j][DFW-1] ^ (j < 2 ? recip_x_i[RW-1] : recip_y_i[RW-1]);
          end
          rmx_q <= recip_x_i[RW-1] ? -$unsigned(recip_x_i) : $unsigned(recip_x_i);
          rmy_q <= recip_y_i[RW-1] ? -$unsigned(recip_y_i) : $unsigned(recip_y_i);
        end
      end
      rbch_pkg::BK_MUL: begin
        // partial product of one slab and one recip half, registered before it is summed
        pp_q <= PPW'(amag_q[cnt_q[2:1]]) * PPW'(b_half);
        pk_q <= cnt_q[2:0];
        if (cnt_q != 4'd0) begin
          if (!pk_q[0]) prod_q[pk_q[2:1]] <= PW'(pp_q);
          else prod_q[pk_q[2:1]] <= prod_q[pk_q[2:1]] + (PW'(pp_q) << HW);
        end
      end
      rbch_pkg::BK_SCALE: begin
        for (int j = 0; j < 4; j++) t_q[j] <= t_val[j];
      end
      rbch_pkg::BK_PMUL: begin
        pmx_q <= MW'(umx) * MW'(best_q);
        pmy_q <= MW'(umy) * MW'(best_q);
      end
      default: ;
    endcase
    if (out_load) begin
      hit_o          <= hit_now;
      hit_body_id_o  <= hit_now ? best_id_q : '0;
      hit_distance_o <= hit_now ? best_q : '0;
      hit_point_x_o  <= hit_now ? hit_coord(origin_x_i, unit_x_i[CW-1], pmx_q) : '0;
      hit_point_y_o  <= hit_now ? hit_coord(origin_y_i, unit_y_i[CW-1], pmy_q) : '0;
    end
  end

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbch_pkg::BK_MUL) |-> (cnt_q <= 4'd8))
    else $error("slab multiply count out of range");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == rbch_pkg::BK_PT))
    else $error("result raised outside hit point stage");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_distance_o == '0 && hit_body_id_o == '0))
    else $error("miss result carries nonzero fields");

endmodule
`default_nettype wire

@@ sv/ray_box_closest_hit_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Nearest hit of one 2D ray against a stream of axis-aligned boxes, signed
// fixed point with FRAC_BITS fraction bits. Program origin, direction and
// max_distance through the write port; each direction write starts a setup,
// which runs the bit-serial square root and the shared restoring divider
// and during which no box is accepted. The front takes one box per cycle,
// while no setup runs and the queue has room, into a four-entry queue and
// drops boxes that are not taken (inactive, or no ray ready) and do not
// close a set. The back works on each taken box with the one shared 33 x 24
// slab multiplier (8 partial products), and on a last box also computes the
// hit point. One result per last box, held in an output register while
// later boxes proceed.
module ray_box_closest_hit_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                          clk_i,
  input  wire                                          rst_ni,
  input  wire                                          cfg_we_i,
  input  wire  logic [rbch_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index_i,
  input  wire  logic [COORD_WIDTH-1:0]                 cfg_data_i,
  input  wire                                          in_valid_i,
  output logic                                         in_ready_o,
  input  wire  logic signed [COORD_WIDTH-1:0]          box_center_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]          box_center_y_i,
  input  wire  logic [COORD_WIDTH-2:0]                 box_half_width_i,
  input  wire  logic [COORD_WIDTH-2:0]                 box_half_height_i,
  input  wire  logic [rbch_pkg::ID_WIDTH-1:0]          box_id_i,
  input  wire                                          box_active_i,
  input  wire                                          last_box_i,
  output logic                                         out_valid_o,
  input  wire                                          out_ready_i,
  output logic                                         hit_o,
  output logic [rbch_pkg::ID_WIDTH-1:0]                hit_body_id_o,
  output logic [COORD_WIDTH-2:0]                       hit_distance_o,
  output logic signed [COORD_WIDTH-1:0]                hit_point_x_o,
  output logic signed [COORD_WIDTH-1:0]                hit_point_y_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int DFW = CW + 2;
  localparam int IDW = rbch_pkg::ID_WIDTH;
  localparam int EW  = 2 + IDW + 4 * DFW;
  localparam int RW  = rbch_pkg::RECIP_WIDTH;

  logic signed [CW-1:0] org_x_q, org_y_q, dir_x_q, dir_y_q;
  logic [CW-2:0]        max_dist_q;
  logic                 start_q;

  rbch_pkg::su_status_t su_status, fe_status;
  logic signed [CW-1:0] unit_x, unit_y;
  logic signed [RW-1:0] recip_x, recip_y;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic                  fe_take, fe_last, q_take, q_last;
  logic [IDW-1:0]        fe_id, q_id;
  logic signed [DFW-1:0] fe_dxl, fe_dxh, fe_dyl, fe_dyh;
  logic signed [DFW-1:0] q_dxl, q_dxh, q_dyl, q_dyh;
  logic [EW-1:0]         push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q    <= '0;
      org_y_q    <= '0;
      dir_x_q    <= '0;
      dir_y_q    <= '0;
      max_dist_q <= '0;
      start_q    <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          rbch_pkg::REG_ORIGIN_X: org_x_q <= cfg_data_i;
          rbch_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data_i;
          rbch_pkg::REG_DIR_X: begin
            dir_x_q <= cfg_data_i;
            start_q <= 1'b1;
          end
          rbch_pkg::REG_DIR_Y: begin
            dir_y_q <= cfg_data_i;
            start_q <= 1'b1;
          end
          rbch_pkg::REG_MAX_DIST: max_dist_q <= cfg_data_i[CW-2:0];
          default: ;
        endcase
      end
    end
  end

  rbch_setup #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .dir_x_i   (dir_x_q),
    .dir_y_i   (dir_y_q),
    .status_o  (su_status),
    .unit_x_o  (unit_x),
    .unit_y_o  (unit_y),
    .recip_x_o (recip_x),
    .recip_y_o (recip_y)
  );

  // hold boxes off while a setup is pending
  assign fe_status.busy      = su_status.busy || start_q;
  assign fe_status.ray_ready = su_status.ray_ready;

  rbch_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .box_center_x_i    (box_center_x_i),
    .box_center_y_i    (box_center_y_i),
    .box_half_width_i  (box_half_width_i),
    .box_half_height_i (box_half_height_i),
    .box_id_i          (box_id_i),
    .box_active_i      (box_active_i),
    .last_box_i        (last_box_i),
    .status_i          (fe_status),
    .origin_x_i        (org_x_q),
    .origin_y_i        (org_y_q),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .take_o            (fe_take),
    .last_o            (fe_last),
    .id_o              (fe_id),
    .dx_lo_o           (fe_dxl),
    .dx_hi_o           (fe_dxh),
    .dy_lo_o           (fe_dyl),
    .dy_hi_o           (fe_dyh)
  );

  assign push_data = {fe_take, fe_last, fe_id, fe_dxl, fe_dxh, fe_dyl, fe_dyh};
  assign {q_take, q_last, q_id, q_dxl, q_dxh, q_dyl, q_dyh} = pop_data;

  rbch_fifo #(.WIDTH(EW), .DEPTH(4)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  rbch_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (pop_valid),
    .q_ready_o      (pop_ready),
    .take_i         (q_take),
    .last_i         (q_last),
    .id_i           (q_id),
    .dx_lo_i        (q_dxl),
    .dx_hi_i        (q_dxh),
    .dy_lo_i        (q_dyl),
    .dy_hi_i        (q_dyh),
    .origin_x_i     (org_x_q),
    .origin_y_i     (org_y_q),
    .max_distance_i (max_dist_q),
    .ray_ready_i    (su_status.ray_ready),
    .unit_x_i       (unit_x),
    .unit_y_i       (unit_y),
    .recip_x_i      (recip_x),
    .recip_y_i      (recip_y),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .hit_body_id_o  (hit_body_id_o),
    .hit_distance_o (hit_distance_o),
    .hit_point_x_o  (hit_point_x_o),
    .hit_point_y_o  (hit_point_y_o)
  );

  a_no_box_in_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (!su_status.busy && !start_q))
    else $error("box transaction taken during ray setup");

endmodule
`default_nettype wire

@@ tb/sv/ray_box_closest_hit_checker.sv @@
`timescale 1ns / 1ps
module ray_box_closest_hit_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                        clk_i,
  input  wire                                        rst_ni,
  input  wire                                        cfg_we_i,
  input  wire  logic [rbch_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire  logic [COORD_WIDTH-1:0]               cfg_data_i,
  input  wire                                        in_valid_i,
  input  wire                                        in_ready_i,
  input  wire  logic signed [COORD_WIDTH-1:0]        box_center_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]        box_center_y_i,
  input  wire  logic [COORD_WIDTH-2:0]               box_half_width_i,
  input  wire  logic [COORD_WIDTH-2:0]               box_half_height_i,
  input  wire  logic [rbch_pkg::ID_WIDTH-1:0]        box_id_i,
  input  wire                                        box_active_i,
  input  wire                                        last_box_i,
  input  wire                                        out_valid_i,
  input  wire                                        out_ready_i,
  input  wire                                        hit_i,
  input  wire  logic [rbch_pkg::ID_WIDTH-1:0]        hit_body_id_i,
  input  wire  logic [COORD_WIDTH-2:0]               hit_distance_i,
  input  wire  logic signed [COORD_WIDTH-1:0]        hit_point_x_i,
  input  wire  logic signed [COORD_WIDTH-1:0]        hit_point_y_i,
  output int                                         pending_o,
  output int                                         failures_o
);

  localparam longint TSAT = (longint'(1) <<< (rbch_pkg::RECIP_WIDTH - 1)) - 1;

  typedef struct {
    logic                          hit;
    logic [rbch_pkg::ID_WIDTH-1:0] id;
    logic [COORD_WIDTH-2:0]        distance;
    logic [COORD_WIDTH-1:0]        px;
    logic [COORD_WIDTH-1:0]        py;
  } hit_report_t;

  hit_report_t hit_reports_q[$];

  longint org_x, org_y, dir_x, dir_y, max_dist;
  longint unit_x, unit_y, recip_x, recip_y;
  bit     ray_ok;
  longint best_dist;
  logic [rbch_pkg::ID_WIDTH-1:0] best_id;
  bit     any_hit;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_component(longint d, longint unsigned len);
    longint unsigned q;
    q = (magnitude(d) << FRAC_BITS) / len;
    if (q > (64'd1 << FRAC_BITS)) q = 64'd1 << FRAC_BITS;
    return signed_of(q, d < 0);
  endfunction

  function automatic longint reciprocal(longint u);
    if (u == 0) return TSAT;
    return signed_of((64'd1 << (2 * FRAC_BITS)) / magnitude(u), u < 0);
  endfunction

  function automatic void normalize_direction();
    longint unsigned ax, ay, len;
    ax = magnitude(dir_x);
    ay = magnitude(dir_y);
    len = root_floor(ax * ax + ay * ay);
    if (len == 0) begin
      ray_ok = 0;
      unit_x = 0; unit_y = 0; recip_x = 0; recip_y = 0;
    end else begin
      ray_ok = 1;
      unit_x = unit_component(dir_x, len);
      unit_y = unit_component(dir_y, len);
      recip_x = reciprocal(unit_x);
      recip_y = reciprocal(unit_y);
    end
  endfunction

  function automatic longint slab_distance(longint diff, longint recip);
    longint unsigned a, b, m;
    a = magnitude(diff);
    b = magnitude(recip);
    if (a == 0 || b == 0) return 0;
    if (b > 64'hFFFF_FFFF_FFFF_FFFF / a) begin
      m = TSAT;
    end else begin
      m = (a * b) >> FRAC_BITS;
      if (m > TSAT) m = TSAT;
    end
    return signed_of(m, (diff < 0) != (recip < 0));
  endfunction

  function automatic logic [COORD_WIDTH-1:0] point_coord(longint o, longint u, longint d);
    longint lo, hi, v;
    longint unsigned p;
    lo = -(longint'(1) <<< (COORD_WIDTH - 1));
    hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    p = (magnitude(u) * longint'(d)) >> FRAC_BITS;
    v = o + signed_of(p, u < 0);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v[COORD_WIDTH-1:0];
  endfunction

  function automatic void predict_box();
    longint t1, t2, t3, t4, tmp, tmin, tmax, t, limit;
    hit_report_t r;
    if (box_active_i && ray_ok) begin
      t1 = slab_distance(longint'(box_center_x_i) - longint'(box_half_width_i) - org_x, recip_x);
      t2 = slab_distance(longint'(box_center_x_i) + longint'(box_half_width_i) - org_x, recip_x);
      t3 = slab_distance(longint'(box_center_y_i) - longint'(box_half_height_i) - org_y, recip_y);
      t4 = slab_distance(longint'(box_center_y_i) + longint'(box_half_height_i) - org_y, recip_y);
      if (t1 > t2) begin tmp = t1; t1 = t2; t2 = tmp; end
      if (t3 > t4) begin tmp = t3; t3 = t4; t4 = tmp; end
      tmin = t3 > t1 ? t3 : t1;
      tmax = t4 < t2 ? t4 : t2;
      if (!(tmin > tmax || tmax < 0)) begin
        t = tmin >= 0 ? tmin : tmax;
        limit = any_hit ? best_dist : max_dist;
        if (t >= 0 && t < limit) begin
          best_dist = t;
          best_id = box_id_i;
          any_hit = 1;
        end
      end
    end
    if (last_box_i) begin
      r.hit = any_hit && ray_ok;
      r.id = r.hit ? best_id : '0;
      r.distance = r.hit ? best_dist[COORD_WIDTH-2:0] : '0;
      r.px = r.hit ? point_coord(org_x, unit_x, best_dist) : '0;
      r.py = r.hit ? point_coord(org_y, unit_y, best_dist) : '0;
      hit_reports_q.push_back(r);
      any_hit = 0;
      best_dist = 0;
      best_id = '0;
    end
  endfunction

  function automatic void apply_write();
    longint s;
    s = longint'($signed(cfg_data_i));
    case (cfg_index_i)
      rbch_pkg::REG_ORIGIN_X: org_x = s;
      rbch_pkg::REG_ORIGIN_Y: org_y = s;
      rbch_pkg::REG_DIR_X: begin dir_x = s; normalize_direction(); end
      rbch_pkg::REG_DIR_Y: begin dir_y = s; normalize_direction(); end
      rbch_pkg::REG_MAX_DIST: max_dist = longint'(cfg_data_i[COORD_WIDTH-2:0]);
      default: ;
    endcase
  endfunction

  initial begin
    failures_o = 0;
    org_x = 0; org_y = 0; dir_x = 0; dir_y = 0; max_dist = 0;
    unit_x = 0; unit_y = 0; recip_x = 0; recip_y = 0;
    ray_ok = 0; best_dist = 0; best_id = '0; any_hit = 0;
  end

  assign pending_o = hit_reports_q.size();

  always @(posedge clk_i) begin
    hit_report_t e;
    if (rst_ni) begin
      if (cfg_we_i) apply_write();
      if (in_valid_i && in_ready_i) predict_box();
      if (out_valid_i && out_ready_i) begin
        if (hit_reports_q.size() == 0) begin
          $error("unexpected transaction: no result pending");
          failures_o++;
        end else begin
          e = hit_reports_q.pop_front();
          if (hit_i !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, hit_i);
            failures_o++;
          end
          if (hit_body_id_i !== e.id) begin
            $error("hit_body_id: expected %0d actual %0d", e.id, hit_body_id_i);
            failures_o++;
          end
          if (hit_distance_i !== e.distance) begin
            $error("hit_distance: expected %0h actual %0h", e.distance, hit_distance_i);
            failures_o++;
          end
          if (hit_point_x_i !== e.px) begin
            $error("hit_point_x: expected %0h actual %0h", e.px, hit_point_x_i);
            failures_o++;
          end
          if (hit_point_y_i !== e.py) begin
            $error("hit_point_y: expected %0h actual %0h", e.py, hit_point_y_i);
            failures_o++;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int SETUP_WAIT = 320;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int BOX_TARGET = 1900;
  localparam int QUIET_FROM = 1700;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [rbch_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [CW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [CW-1:0] box_center_x_i = '0;
  logic signed [CW-1:0] box_center_y_i = '0;
  logic [CW-2:0] box_half_width_i = '0;
  logic [CW-2:0] box_half_height_i = '0;
  logic [rbch_pkg::ID_WIDTH-1:0] box_id_i = '0;
  logic box_active_i = 0;
  logic last_box_i = 0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic hit_o;
  logic [rbch_pkg::ID_WIDTH-1:0] hit_body_id_o;
  logic [CW-2:0] hit_distance_o;
  logic signed [CW-1:0] hit_point_x_o;
  logic signed [CW-1:0] hit_point_y_o;
  int pending, failures;
  int boxes_sent = 0;
  int cycles = 0;

  // current ray as seen by the stimulus, used to aim boxes
  real ray_ox, ray_oy, ray_ux, ray_uy;

  always #1 clk_i = ~clk_i;

  ray_box_closest_hit_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (.*);

  ray_box_closest_hit_checker #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .box_center_x_i, .box_center_y_i, .box_half_width_i, .box_half_height_i,
    .box_id_i, .box_active_i, .last_box_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .hit_i(hit_o), .hit_body_id_i(hit_body_id_o), .hit_distance_i(hit_distance_o),
    .hit_point_x_i(hit_point_x_o), .hit_point_y_i(hit_point_y_o),
    .pending_o(pending), .failures_o(failures)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ray_box_closest_hit_top verification failed");
      $finish;
    end
  end

  // receiver stalls in bursts until the quiet tail
  always @(negedge clk_i) begin
    int stall;
    if (stall > 0) begin
      stall--;
      out_ready_i <= 0;
    end else if (boxes_sent < QUIET_FROM && $urandom_range(0, 9) == 0) begin
      stall = $urandom_range(1, 14) - 1;
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  function automatic logic [CW-1:0] clamp_fx(real v);
    if (v > 2147483647.0) return 32'h7FFF_FFFF;
    if (v < -2147483648.0) return 32'h8000_0000;
    return CW'($rtoi(v));
  endfunction

  task automatic write_reg(rbch_pkg::cfg_reg_e idx, logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    if (idx == rbch_pkg::REG_DIR_X || idx == rbch_pkg::REG_DIR_Y)
      repeat (SETUP_WAIT) @(negedge clk_i);
  endtask

  task automatic load_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] dx,
                          logic [CW-1:0] dy, logic [CW-2:0] maxd);
    real l;
    // drop valid once the last box of the set is taken
    in_valid_i <= 0;
    wait (pending == 0);
    repeat (SETUP_WAIT) @(negedge clk_i);
    write_reg(rbch_pkg::REG_ORIGIN_X, ox);
    write_reg(rbch_pkg::REG_ORIGIN_Y, oy);
    write_reg(rbch_pkg::REG_DIR_X, dx);
    write_reg(rbch_pkg::REG_DIR_Y, dy);
    write_reg(rbch_pkg::REG_MAX_DIST, {1'b0, maxd});
    ray_ox = $itor($signed(ox));
    ray_oy = $itor($signed(oy));
    l = $sqrt($itor($signed(dx)) ** 2 + $itor($signed(dy)) ** 2);
    ray_ux = l > 0 ? $itor($signed(dx)) / l : 0;
    ray_uy = l > 0 ? $itor($signed(dy)) / l : 0;
  endtask

  task automatic send_box(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-2:0] hw,
                          logic [CW-2:0] hh, logic [rbch_pkg::ID_WIDTH-1:0] id, logic act,
                          logic lst);
    int gap;
    if (boxes_sent < QUIET_FROM && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1;
    box_center_x_i <= cx;
    box_center_y_i <= cy;
    box_half_width_i <= hw;
    box_half_height_i <= hh;
    box_id_i <= id;
    box_active_i <= act;
    last_box_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    boxes_sent++;
  endtask

  // box aimed near the ray, or full-range noise now and then
  task automatic random_box(logic lst);
    real t, cx, cy;
    if ($urandom_range(0, 9) == 0) begin
      send_box($urandom, $urandom, 31'($urandom), 31'($urandom), 16'($urandom),
               1'($urandom), lst);
    end else begin
      t = $itor($urandom_range(0, 400)) * 65536.0 - 40.0 * 65536.0;
      cx = ray_ox + ray_ux * t + $itor($signed($urandom_range(0, 40 << 16))) - 20.0 * 65536.0;
      cy = ray_oy + ray_uy * t + $itor($signed($urandom_range(0, 40 << 16))) - 20.0 * 65536.0;
      send_box(clamp_fx(cx), clamp_fx(cy), 31'($urandom_range(0, 30 << 16)),
               31'($urandom_range(0, 30 << 16)), 16'($urandom),
               $urandom_range(0, 7) != 0, lst);
    end
  endtask

  task automatic random_ray();
    logic [CW-1:0] ox, oy, dx, dy;
    logic [CW-2:0] maxd;
    int sel;
    sel = $urandom_range(0, 19);
    ox = sel == 0 ? $urandom : CW'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    oy = sel == 1 ? $urandom : CW'($signed($urandom_range(0, 200 << 16)) - (100 << 16));
    dx = sel == 2 ? '0 : (sel < 8 ? $urandom : CW'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
    dy = sel == 3 ? '0 : (sel < 8 ? $urandom : CW'($signed($urandom_range(0, 8 << 16)) - (4 << 16)));
    if (sel == 4) begin dx = '0; dy = '0; end
    case ($urandom_range(0, 5))
      0: maxd = '0;
      1: maxd = '1;
      2: maxd = 31'($urandom);
      default: maxd = 31'($urandom_range(50 << 16, 500 << 16));
    endcase
    load_ray(ox, oy, dx, dy, maxd);
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // unknown register indexes are ignored
    for (int i = int'(rbch_pkg::REG_MAX_DIST) + 1; i < (1 << rbch_pkg::CFG_INDEX_WIDTH); i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1;
      cfg_index_i <= rbch_pkg::CFG_INDEX_WIDTH'(i);
      cfg_data_i <= $urandom;
      @(negedge clk_i);
      cfg_we_i <= 0;
    end

    // zero direction after reset: skipped boxes, no hit
    send_box(32'h0001_0000, 0, 31'h1_0000, 31'h1_0000, 16'd7, 1, 1);

    // axis ray, one zero component
    load_ray(0, 0, 32'h0001_0000, 0, 31'h7FFF_FFFF);
    send_box(32'h0005_0000, 0, 31'h1_0000, 31'h1_0000, 16'd1, 1, 0);
    send_box(32'h0005_0000, 0, 31'h1_0000, 31'h1_0000, 16'd2, 1, 0);  // tie: first wins
    send_box(32'h0002_0000, 0, 31'h1_0000, 31'h1_0000, 16'hFFFF, 0, 0);
    send_box(32'h0003_0000, 0, 31'h1_0000, 31'h1_0000, 16'd3, 1, 1);
    send_box(0, 0, 31'h4_0000, 31'h4_0000, 16'd4, 1, 0);            // origin inside
    send_box(32'h7FFF_FFFF, 32'h8000_0000, '1, '1, 16'hFFFF, 1, 0);
    send_box(32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 16'd0, 1, 0);
    send_box(32'h0009_0000, 0, 31'h1_0000, 31'h1_0000, 16'd5, 0, 1); // inactive last

    // extreme origin and direction, max_distance zero then full
    load_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_box(32'h8000_0000, 32'h7FFF_FFFF, '1, '1, 16'd9, 1, 1);
    load_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, '1);
    send_box(32'h7FFF_0000, 32'h8001_0000, '1, '1, 16'd10, 1, 0);
    send_box(0, 0, '1, '1, 16'd11, 1, 1);

    while (boxes_sent < BOX_TARGET) begin
      random_ray();
      repeat ($urandom_range(1, 6)) begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) random_box(i == n - 1);
      end
    end
    in_valid_i <= 0;

    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    if (failures == 0) begin
      $display("ray_box_closest_hit_top verification clean");
    end else begin
      $display("ray_box_closest_hit_top verification failed");
    end
    $finish;
  end

endmodule
